// ===== src/crc32zs_pkg.sv =====
// Package: constants, opcodes and CRC helper functions for the running CRC-32 unit.
`timescale 1ns / 1ps
`default_nettype none

package crc32zs_pkg;

  // Reflected CRC-32 polynomial.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Width of the zero-run length field and default number of bits used from it.
  localparam int ZERO_FIELD_W       = 48;
  localparam int COUNT_BITS_DEFAULT = 48;
  localparam int ZOP_IDX_W          = $clog2(ZERO_FIELD_W);

  // One operator multiplication takes one step per bit of the operator word.
  localparam int MUL_STEPS  = 32;
  localparam int MUL_STEP_W = $clog2(MUL_STEPS);

  // Opcodes of an input item.
  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_BYTE     = 2'd1;
  localparam logic [1:0] OP_ZERO_RUN = 2'd2;

  typedef logic [31:0] zop_tab_t [ZERO_FIELD_W];

  // One reflected shift of the register with a zero input bit (multiply by x).
  function automatic logic [31:0] bit_step(logic [31:0] r);
    return (r >> 1) ^ (r[0] ? CRC_POLY : 32'h0);
  endfunction

  // Absorb one data byte; equivalent to the usual 256-entry table rule.
  function automatic logic [31:0] byte_step(logic [31:0] crc, logic [7:0] data);
    logic [31:0] r;
    r = {24'h0, crc[7:0] ^ data};
    for (int i = 0; i < 8; i++) begin
      r = bit_step(r);
    end
    return r ^ (crc >> 8);
  endfunction

  // Product of two reflected polynomials modulo the CRC polynomial.
  // Only evaluated at elaboration to build the operator table.
  function automatic logic [31:0] mul_mod(logic [31:0] a, logic [31:0] b);
    logic [31:0] p;
    logic [31:0] bb;
    p  = 32'h0;
    bb = b;
    for (int i = 0; i < 32; i++) begin
      if (a[31-i]) begin
        p = p ^ bb;
      end
      bb = bit_step(bb);
    end
    return p;
  endfunction

  // Entry k is x^(8*2^k) mod P: the operator that absorbs 2^k zero bytes.
  function automatic zop_tab_t build_zero_ops();
    zop_tab_t    t;
    logic [31:0] x;
    x = 32'h4000_0000;
    x = mul_mod(x, x);
    x = mul_mod(x, x);
    for (int k = 0; k < ZERO_FIELD_W; k++) begin
      x    = mul_mod(x, x);
      t[k] = x;
    end
    return t;
  endfunction

  localparam zop_tab_t ZERO_OP = build_zero_ops();

endpackage

`default_nettype wire

// ===== src/crc32zs_cmd_if.sv =====
// Interface: command channel carrying one input item of the running CRC unit.
`timescale 1ns / 1ps
`default_nettype none

interface crc32zs_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            opcode;
  logic [31:0]                           start_value;
  logic [7:0]                            data_byte;
  logic [crc32zs_pkg::ZERO_FIELD_W-1:0]  zero_count;

  modport source (output valid, opcode, start_value, data_byte, zero_count, input ready);
  modport sink   (input valid, opcode, start_value, data_byte, zero_count, output ready);
endinterface

`default_nettype wire

// ===== src/crc32zs_res_if.sv =====
// Interface: result channel carrying the CRC register after each item.
`timescale 1ns / 1ps
`default_nettype none

interface crc32zs_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;

  modport source (output valid, crc_value, input ready);
  modport sink   (input valid, crc_value, output ready);
endinterface

`default_nettype wire

// ===== src/crc32_running_with_zero_skip_unit.sv =====
// Top level: running reflected CRC-32 register with load, byte and zero-run commands.
//
//   Channel | Direction | Payload                                         | Handshake
//   cmd     | in        | opcode, start_value, data_byte, zero_count      | valid/ready
//   result  | out       | crc_value                                       | valid/ready
//
// Load, byte and undefined opcodes leave their result in the cycle after acceptance;
// an item may enter every cycle while the result side keeps taking items.
// A zero run is worked off between acceptance and result by the sequencer, which
// scans one count bit a cycle from the lowest up and ends after the highest set bit;
// for each set bit the scan waits for 32 passes of the shared bit-serial GF(2) multiplier.
// cmd.ready is low for the whole run.
// Synchronous reset sets the register to all ones and empties the result stage.
// A result waits in the output stage until taken; the CRC register doubles as it.
`timescale 1ns / 1ps
`default_nettype none

module crc32_running_with_zero_skip_unit #(
  parameter int COUNT_BITS = crc32zs_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  crc32zs_cmd_if.sink         cmd,
  crc32zs_res_if.source       result
);

  // Count bits that take part; higher bits of the field are ignored.
  localparam int USED_W = (COUNT_BITS < crc32zs_pkg::ZERO_FIELD_W) ?
                          COUNT_BITS : crc32zs_pkg::ZERO_FIELD_W;
  localparam logic [crc32zs_pkg::MUL_STEP_W-1:0] STEP_LAST =
    crc32zs_pkg::MUL_STEP_W'(crc32zs_pkg::MUL_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_MUL  = 3'b100
  } state_t;

  state_t                                 state;
  logic                                   out_valid;
  logic                                   out_valid_next;
  logic                                   res_done;
  logic [31:0]                            crc;
  logic [USED_W-1:0]                      run_left;
  logic [crc32zs_pkg::ZOP_IDX_W-1:0]      bit_idx;
  logic [31:0]                            op_a;
  logic [31:0]                            mul_b;
  logic [31:0]                            acc;
  logic [31:0]                            acc_next;
  logic [crc32zs_pkg::MUL_STEP_W-1:0]     step;
  logic                                   cmd_acc;

  // Handshakes: a new item enters only when idle and the result stage is free.
  assign cmd.ready        = (state == ST_IDLE) && (!out_valid || result.ready);
  assign cmd_acc          = cmd.valid && cmd.ready;
  assign result.valid     = out_valid;
  assign result.crc_value = crc;

  // A result appears after a load, byte or undefined command or when a zero run finishes.
  assign res_done       = (cmd_acc && (cmd.opcode != crc32zs_pkg::OP_ZERO_RUN)) ||
                          ((state == ST_SCAN) && (run_left == '0));
  assign out_valid_next = res_done ? 1'b1 :
                          ((result.valid && result.ready) ? 1'b0 : out_valid);

  // Shared multiplier step: add the shifted register when the operator bit is set.
  assign acc_next = op_a[31] ? (acc ^ mul_b) : acc;

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      crc       <= '1;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        ST_IDLE: begin
          if (cmd_acc) begin
            unique case (cmd.opcode)
              crc32zs_pkg::OP_LOAD: begin
                crc <= cmd.start_value;
              end
              crc32zs_pkg::OP_BYTE: begin
                crc <= crc32zs_pkg::byte_step(crc, cmd.data_byte);
              end
              crc32zs_pkg::OP_ZERO_RUN: begin
                run_left <= cmd.zero_count[USED_W-1:0];
                bit_idx  <= '0;
                state    <= ST_SCAN;
              end
              default: begin
                // Undefined opcode: report the register unchanged.
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (run_left == '0) begin
            state <= ST_IDLE;
          end else if (run_left[0]) begin
            op_a  <= crc32zs_pkg::ZERO_OP[bit_idx];
            mul_b <= crc;
            acc   <= '0;
            step  <= '0;
            state <= ST_MUL;
          end else begin
            run_left <= run_left >> 1;
            bit_idx  <= bit_idx + 1'b1;
          end
        end
        ST_MUL: begin
          acc   <= acc_next;
          op_a  <= op_a << 1;
          mul_b <= crc32zs_pkg::bit_step(mul_b);
          step  <= step + 1'b1;
          if (step == STEP_LAST) begin
            crc      <= acc_next;
            run_left <= run_left >> 1;
            bit_idx  <= bit_idx + 1'b1;
            state    <= ST_SCAN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // No item may enter while a zero run is in progress.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !cmd.ready)
    else $error("command accepted while a zero run is in progress");

  // A load, byte or undefined command leaves a result in the output stage.
  a_short_op_result: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && (cmd.opcode != crc32zs_pkg::OP_ZERO_RUN)) |=> out_valid)
    else $error("single-cycle command produced no result");

  // The multiplier hands back to the scanner after exactly its last step.
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_MUL) && (step == STEP_LAST)) |=> (state == ST_SCAN))
    else $error("multiplier did not return to the scanner");

  // An exhausted count finishes the run with a result.
  a_run_result: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && (run_left == '0)) |=> (out_valid && (state == ST_IDLE)))
    else $error("zero run ended without a result");

  // No result is shown while the register is being multiplied.
  a_no_result_mid_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> !out_valid)
    else $error("result shown during a zero run");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for the running CRC-32 unit: directed table, then random items against a predictor.
`timescale 1ns / 1ps

module tb;

  localparam int          COUNT_W      = crc32zs_pkg::ZERO_FIELD_W;
  localparam int          RUN_OPS      = crc32zs_pkg::COUNT_BITS_DEFAULT;
  localparam logic [1:0]  OP_UNDEFINED = 2'd3;
  localparam int          DIRECTED_N   = 22;
  localparam int          RANDOM_N     = 1250;
  localparam int          IDLE_LIMIT   = 20000;
  localparam int          DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        start_value;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] zero_count;
    logic               known;
    logic [31:0]        crc_value;
  } stim_row_t;

  logic clk;
  logic rst;

  crc32zs_cmd_if cmd_bus ();
  crc32zs_res_if result_bus ();

  crc32_running_with_zero_skip_unit dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_bus),
    .result (result_bus)
  );

  // Columns of the operators that absorb 2^k zero bytes.
  logic [31:0]  run_op [RUN_OPS][32];
  logic [31:0]  crc_model;
  logic [31:0]  crc_expected [$];
  stim_row_t    directed [DIRECTED_N];
  bit           idling_on;
  int           fail_count = 0;
  int           results_checked = 0;
  int           load_items, byte_items, run_items, undef_items;
  int           ready_hold;
  int           idle_cycles = 0;

  // Clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    if (!idling_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Square the one-bit operator repeatedly; from eight bits on, keep each power.
  task automatic build_run_ops();
    logic [31:0] m  [32];
    logic [31:0] sq [32];
    logic [31:0] acc;
    m[0] = crc32zs_pkg::CRC_POLY;
    for (int c = 1; c < 32; c++) begin
      m[c] = 32'h1 << (c - 1);
    end
    for (int s = 0; s < RUN_OPS + 2; s++) begin
      for (int c = 0; c < 32; c++) begin
        acc = 32'h0;
        for (int j = 0; j < 32; j++) begin
          if (m[c][j]) begin
            acc = acc ^ m[j];
          end
        end
        sq[c] = acc;
      end
      for (int c = 0; c < 32; c++) begin
        m[c] = sq[c];
      end
      if (s >= 2) begin
        for (int c = 0; c < 32; c++) begin
          run_op[s-2][c] = m[c];
        end
      end
    end
  endtask

  function automatic logic [31:0] absorb_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] r;
    r = {24'h0, crc[7:0] ^ data};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (r[0] ? crc32zs_pkg::CRC_POLY : 32'h0);
    end
    return r ^ (crc >> 8);
  endfunction

  function automatic logic [31:0] absorb_zero_run(logic [31:0] crc, logic [COUNT_W-1:0] n);
    logic [31:0] acc;
    for (int k = 0; k < RUN_OPS; k++) begin
      if (n[k]) begin
        acc = 32'h0;
        for (int c = 0; c < 32; c++) begin
          if (crc[c]) begin
            acc = acc ^ run_op[k][c];
          end
        end
        crc = acc;
      end
    end
    return crc;
  endfunction

  function automatic logic [31:0] next_crc(logic [31:0] crc, logic [1:0] op, logic [31:0] sv,
                                           logic [7:0] db, logic [COUNT_W-1:0] zc);
    case (op)
      crc32zs_pkg::OP_LOAD:     return sv;
      crc32zs_pkg::OP_BYTE:     return absorb_byte(crc, db);
      crc32zs_pkg::OP_ZERO_RUN: return absorb_zero_run(crc, zc);
      default:                  return crc;
    endcase
  endfunction

  // Offer one item, wait for acceptance, then record what it should return.
  task automatic send_item(logic [1:0] op, logic [31:0] sv, logic [7:0] db,
                           logic [COUNT_W-1:0] zc, logic known, logic [31:0] known_crc);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.opcode      <= op;
    cmd_bus.start_value <= sv;
    cmd_bus.data_byte   <= db;
    cmd_bus.zero_count  <= zc;
    do @(posedge clk); while (!cmd_bus.ready);
    crc_model = next_crc(crc_model, op, sv, db, zc);
    crc_expected.push_back(known ? known_crc : crc_model);
    case (op)
      crc32zs_pkg::OP_LOAD:     load_items++;
      crc32zs_pkg::OP_BYTE:     byte_items++;
      crc32zs_pkg::OP_ZERO_RUN: run_items++;
      default:                  undef_items++;
    endcase
  endtask

  // Hold the next item back until every outstanding result has come out.
  task automatic wait_for_results();
    cmd_bus.valid <= 1'b0;
    while (crc_expected.size() != 0) @(posedge clk);
  endtask

  // Receiver: takes results with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      result_bus.ready <= 1'b0;
      ready_hold--;
    end else begin
      result_bus.ready <= 1'b1;
      ready_hold = gap_len();
    end
  end

  // Result checker: each result against the oldest expectation.
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (crc_expected.size() == 0) begin
        $error("crc_value: unexpected result %h with nothing expected", result_bus.crc_value);
        fail_count++;
      end else begin
        want = crc_expected.pop_front();
        results_checked++;
        if (result_bus.crc_value !== want) begin
          $error("crc_value: expected %h, actual %h", want, result_bus.crc_value);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("crc32_running_with_zero_skip_unit: mismatch");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [1:0]         op;
    logic [COUNT_W-1:0] zc;
    logic [COUNT_W-1:0] mask;
    int                 r;
    int                 w;

    rst                 = 1'b1;
    cmd_bus.valid       = 1'b0;
    cmd_bus.opcode      = crc32zs_pkg::OP_LOAD;
    cmd_bus.start_value = 32'h0;
    cmd_bus.data_byte   = 8'h0;
    cmd_bus.zero_count  = '0;
    idling_on           = 1'b1;
    load_items          = 0;
    byte_items          = 0;
    run_items           = 0;
    undef_items         = 0;
    crc_model           = 32'hFFFF_FFFF;
    build_run_ops();

    // Directed rows; a known value is given where it follows directly.
    directed = '{
      '{OP_UNDEFINED,             32'h0,         8'h00, 48'h0,            1'b1, 32'hFFFF_FFFF},
      '{crc32zs_pkg::OP_ZERO_RUN, 32'h0,         8'h00, 48'h0,            1'b1, 32'hFFFF_FFFF},
      '{crc32zs_pkg::OP_LOAD,     32'h0,         8'h00, 48'h0,            1'b1, 32'h0},
      '{crc32zs_pkg::OP_BYTE,     32'h0,         8'h00, 48'h0,            1'b1, 32'h0},
      '{crc32zs_pkg::OP_ZERO_RUN, 32'h0,         8'h00, 48'hFFFF_FFFF_FFFF, 1'b1, 32'h0},
      '{crc32zs_pkg::OP_BYTE,     32'h0,         8'hFF, 48'h0,            1'b0, 32'h0},
      '{crc32zs_pkg::OP_LOAD,     32'hFFFF_FFFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{crc32zs_pkg::OP_BYTE,     32'h0,         8'h31, 48'h0,            1'b0, 32'h0},
      '{crc32zs_pkg::OP_BYTE,     32'h0,         8'h32, 48'h0,            1'b0, 32'h0},
      '{crc32zs_pkg::OP_BYTE,     32'h0,         8'h33, 48'h0,            1'b0, 32'h0},
      '{crc32zs_pkg::OP_BYTE,     32'h0,         8'h34, 48'h0,            1'b0, 32'h0},
      '{crc32zs_pkg::OP_BYTE,     32'h0,         8'h35, 48'h0,            1'b0, 32'h0},
      '{crc32zs_pkg::OP_BYTE,     32'h0,         8'h36, 48'h0,            1'b0, 32'h0},
      '{crc32zs_pkg::OP_BYTE,     32'h0,         8'h37, 48'h0,            1'b0, 32'h0},
      '{crc32zs_pkg::OP_BYTE,     32'h0,         8'h38, 48'h0,            1'b0, 32'h0},
      '{crc32zs_pkg::OP_BYTE,     32'h0,         8'h39, 48'h0,            1'b1, 32'h340B_C6D9},
      '{crc32zs_pkg::OP_ZERO_RUN, 32'h0,         8'h00, 48'h1,            1'b0, 32'h0},
      '{crc32zs_pkg::OP_ZERO_RUN, 32'h0,         8'h00, 48'h8000_0000_0000, 1'b0, 32'h0},
      '{OP_UNDEFINED,             32'hA5A5_5A5A, 8'hC3, 48'hFFFF_FFFF_FFFF, 1'b0, 32'h0},
      '{crc32zs_pkg::OP_LOAD,     32'hDEAD_BEEF, 8'h5A, 48'h1234_5678_9ABC, 1'b1, 32'hDEAD_BEEF},
      '{crc32zs_pkg::OP_ZERO_RUN, 32'h0,         8'hFF, 48'h5555_5555_5555, 1'b0, 32'h0},
      '{crc32zs_pkg::OP_BYTE,     32'hFFFF_FFFF, 8'h80, 48'hFFFF_FFFF_FFFF, 1'b0, 32'h0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_N; i++) begin
      send_item(directed[i].opcode, directed[i].start_value, directed[i].data_byte,
                directed[i].zero_count, directed[i].known, directed[i].crc_value);
    end
    wait_for_results();

    // Random items; unused fields always carry noise.
    for (int i = 0; i < RANDOM_N; i++) begin
      idling_on = !((i >= 400 && i < 520) || (i >= 900 && i < 1000));
      if (i % 250 == 249) begin
        wait_for_results();
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        op = crc32zs_pkg::OP_LOAD;
      end else if (r < 65) begin
        op = crc32zs_pkg::OP_BYTE;
      end else if (r < 95) begin
        op = crc32zs_pkg::OP_ZERO_RUN;
      end else begin
        op = OP_UNDEFINED;
      end
      // Mostly short runs, with the full count width now and then.
      r = $urandom_range(0, 99);
      if (r < 70) begin
        w = $urandom_range(1, 8);
      end else if (r < 90) begin
        w = $urandom_range(9, 24);
      end else begin
        w = $urandom_range(25, COUNT_W);
      end
      mask = (w >= COUNT_W) ? {COUNT_W{1'b1}} : (({{(COUNT_W-1){1'b0}}, 1'b1} << w) - 1'b1);
      zc   = COUNT_W'({$urandom, $urandom});
      zc   = zc & mask;
      send_item(op, $urandom, 8'($urandom_range(0, 255)), zc, 1'b0, 32'h0);
    end
    cmd_bus.valid <= 1'b0;

    while (crc_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads, %0d data bytes, %0d zero runs and %0d undefined opcodes;",
             load_items, byte_items, run_items, undef_items);
    $display("%0d results checked against the predicted register, %0d failures.",
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("crc32_running_with_zero_skip_unit: match");
    end else begin
      $display("crc32_running_with_zero_skip_unit: mismatch");
    end
    $finish;
  end

endmodule
